[rtl/trp_pkg.sv]
// shared types, constants and helpers of the turtle raster plotter
`default_nettype none

package trp_pkg;

	// grid size
	localparam int GRID_ROWS = 32;
	localparam int GRID_COLS = 32;
	localparam int ROW_W = $clog2(GRID_ROWS);
	localparam int COL_W = $clog2(GRID_COLS);
	localparam int OUT_ROWS = (GRID_ROWS < 32) ? GRID_ROWS : 32;

	// item field widths
	localparam int OPCODE_W = 4;
	localparam int STEPS_W = 6;
	localparam int ROW_IDX_W = 5;
	localparam int ROW_BITS_W = 32;

	// width for position and step arithmetic, one spare bit
	localparam int POS_MAX_W = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int SPAN_W = ((POS_MAX_W > STEPS_W) ? POS_MAX_W : STEPS_W) + 1;

	// configuration registers
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;
	localparam int START_W = 5;
	localparam int HEAD_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_COL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 2'd2;

	// headings
	localparam logic [HEAD_W-1:0] HEAD_NORTH = 2'd0;
	localparam logic [HEAD_W-1:0] HEAD_EAST = 2'd1;
	localparam logic [HEAD_W-1:0] HEAD_SOUTH = 2'd2;
	localparam logic [HEAD_W-1:0] HEAD_WEST = 2'd3;

	localparam logic [START_W-1:0] RST_START_ROW = 5'd0;
	localparam logic [START_W-1:0] RST_START_COL = 5'd0;
	localparam logic [HEAD_W-1:0] RST_START_HEADING = HEAD_SOUTH;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_PEN_UP = 4'd1;
	localparam logic [OPCODE_W-1:0] OP_PEN_DOWN = 4'd2;
	localparam logic [OPCODE_W-1:0] OP_RIGHT = 4'd3;
	localparam logic [OPCODE_W-1:0] OP_LEFT = 4'd4;
	localparam logic [OPCODE_W-1:0] OP_MOVE = 4'd5;
	localparam logic [OPCODE_W-1:0] OP_DISPLAY = 4'd6;
	localparam logic [OPCODE_W-1:0] OP_END = 4'd9;

	// result kinds
	localparam logic KIND_ROW = 1'b0;
	localparam logic KIND_ERR = 1'b1;

	typedef enum logic [2:0] {
		CMD_PEN_UP,
		CMD_PEN_DOWN,
		CMD_RIGHT,
		CMD_LEFT,
		CMD_MOVE,
		CMD_NOP,
		CMD_END,
		CMD_BAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [STEPS_W-1:0] steps;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	typedef struct packed {
		logic [START_W-1:0] row;
		logic [START_W-1:0] col;
		logic [HEAD_W-1:0] heading;
	} start_cfg_t;

	typedef struct packed {
		logic en;
		logic [ROW_W-1:0] addr;
	} mem_rd_req_t;

	typedef struct packed {
		logic en;
		logic [ROW_W-1:0] addr;
		logic [GRID_COLS-1:0] data;
	} mem_wr_req_t;

	function automatic logic [ROW_W-1:0] clamp_row(input logic [START_W-1:0] v);
		if (32'(v) >= GRID_ROWS) begin
			return ROW_W'(GRID_ROWS - 1);
		end
		return ROW_W'(v);
	endfunction

	function automatic logic [COL_W-1:0] clamp_col(input logic [START_W-1:0] v);
		if (32'(v) >= GRID_COLS) begin
			return COL_W'(GRID_COLS - 1);
		end
		return COL_W'(v);
	endfunction

endpackage

`default_nettype wire

[rtl/trp_front.sv]
// command intake: decode of opcodes and a two-entry command queue
`default_nettype none

module trp_front
	import trp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire logic [STEPS_W-1:0]  steps,
	input  wire logic                pop,
	output q_head_t                  head
);

	localparam int Q_DEPTH = 2;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	cmd_t q_mem_q [Q_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	cmd_t cls;
	logic accept;
	logic push;

	// classify; display and zero-length moves do nothing and are dropped
	always_comb begin
		cls.steps = steps;
		case (opcode)
			OP_PEN_UP:   cls.kind = CMD_PEN_UP;
			OP_PEN_DOWN: cls.kind = CMD_PEN_DOWN;
			OP_RIGHT:    cls.kind = CMD_RIGHT;
			OP_LEFT:     cls.kind = CMD_LEFT;
			OP_MOVE:     cls.kind = (steps == '0) ? CMD_NOP : CMD_MOVE;
			OP_DISPLAY:  cls.kind = CMD_NOP;
			OP_END:      cls.kind = CMD_END;
			default:     cls.kind = CMD_BAD;
		endcase
	end

	assign cmd_stall = (count_q == Q_CNT_W'(Q_DEPTH));
	assign accept = cmd_valid && !cmd_stall;
	assign push = accept && (cls.kind != CMD_NOP);

	assign head.valid = (count_q != '0);
	assign head.cmd = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + Q_CNT_W'(push) - Q_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

endmodule

`default_nettype wire

[rtl/trp_grid_mem.sv]
// grid row memory with per-row valid bits, registered read
`default_nettype none

module trp_grid_mem
	import trp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mem_rd_req_t rd_req,
	output logic [GRID_COLS-1:0] rd_data,
	input  wire mem_wr_req_t wr_req
);

	logic [GRID_COLS-1:0] mem [GRID_ROWS];
	logic [GRID_ROWS-1:0] row_valid_q;
	logic [GRID_COLS-1:0] rd_q;
	logic rd_valid_q;

	// rows never written since reset read as blank
	assign rd_data = rd_valid_q ? rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_req.en) begin
				row_valid_q[wr_req.addr] <= 1'b1;
			end
			if (rd_req.en) begin
				rd_valid_q <= row_valid_q[rd_req.addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem[wr_req.addr] <= wr_req.data;
		end
		if (rd_req.en) begin
			rd_q <= mem[rd_req.addr];
		end
	end

endmodule

`default_nettype wire

[rtl/trp_back.sv]
// command execution: turtle state, paint sequencer, raster stream and result register
`default_nettype none

module trp_back
	import trp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire start_cfg_t            start_cfg,
	input  wire q_head_t               head,
	output logic                       pop,
	output mem_rd_req_t                rd_req,
	input  wire logic [GRID_COLS-1:0]  rd_data,
	output mem_wr_req_t                wr_req,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic                       kind,
	output logic [ROW_IDX_W-1:0]       row_index,
	output logic [ROW_BITS_W-1:0]      row_bits,
	output logic                       last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAINT,
		ST_READ,
		ST_EMIT,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic valid;
		logic [ROW_W-1:0] row;
		logic [GRID_COLS-1:0] mask;
		logic pen;
	} paint_t;

	state_t state_q;
	logic [ROW_W-1:0] pos_row_q;
	logic [COL_W-1:0] pos_col_q;
	logic [HEAD_W-1:0] heading_q;
	logic pen_q;
	logic [ROW_W-1:0] cur_q;
	logic [ROW_W-1:0] end_q;
	logic [GRID_COLS-1:0] mask_q;
	paint_t paint_s1;
	logic res_valid_q;
	logic kind_q;
	logic [ROW_IDX_W-1:0] row_index_q;
	logic [ROW_BITS_W-1:0] row_bits_q;
	logic last_q;

	logic out_free;
	logic [SPAN_W-1:0] r_w, c_w, n_w, nm1_w;
	logic [SPAN_W-1:0] lo_w, hi_w, new_row_w, new_col_w;
	logic vert;
	logic [GRID_COLS-1:0] hmask;

	assign out_free = !res_valid_q || !res_stall;
	assign pop = (state_q == ST_IDLE) && head.valid && !paint_s1.valid;

	// move geometry from the current turtle state
	always_comb begin
		r_w = SPAN_W'(pos_row_q);
		c_w = SPAN_W'(pos_col_q);
		n_w = SPAN_W'(head.cmd.steps);
		nm1_w = n_w - SPAN_W'(1);
		vert = 1'b1;
		lo_w = r_w;
		hi_w = r_w;
		new_row_w = r_w;
		new_col_w = c_w;
		case (heading_q)
			HEAD_NORTH: begin
				lo_w = (nm1_w > r_w) ? '0 : r_w - nm1_w;
				new_row_w = (n_w > r_w) ? '0 : r_w - n_w;
			end
			HEAD_SOUTH: begin
				hi_w = (r_w + nm1_w >= SPAN_W'(GRID_ROWS)) ? SPAN_W'(GRID_ROWS - 1)
					: r_w + nm1_w;
				new_row_w = (r_w + n_w >= SPAN_W'(GRID_ROWS)) ? SPAN_W'(GRID_ROWS - 1)
					: r_w + n_w;
			end
			HEAD_EAST: begin
				vert = 1'b0;
				lo_w = c_w;
				hi_w = (c_w + nm1_w >= SPAN_W'(GRID_COLS)) ? SPAN_W'(GRID_COLS - 1)
					: c_w + nm1_w;
				new_col_w = (c_w + n_w >= SPAN_W'(GRID_COLS)) ? SPAN_W'(GRID_COLS - 1)
					: c_w + n_w;
			end
			default: begin
				vert = 1'b0;
				lo_w = (nm1_w > c_w) ? '0 : c_w - nm1_w;
				hi_w = c_w;
				new_col_w = (n_w > c_w) ? '0 : c_w - n_w;
			end
		endcase
		for (int j = 0; j < GRID_COLS; j++) begin
			hmask[j] = (SPAN_W'(j) >= lo_w) && (SPAN_W'(j) <= hi_w);
		end
	end

	// one row read per cycle while painting; the read-modify-write lands in the cycle after the read
	always_comb begin
		rd_req.en = (state_q == ST_PAINT) || (state_q == ST_READ);
		rd_req.addr = cur_q;
		wr_req.en = paint_s1.valid;
		wr_req.addr = paint_s1.row;
		wr_req.data = paint_s1.pen ? (rd_data | paint_s1.mask) : (rd_data & ~paint_s1.mask);
	end

	assign res_valid = res_valid_q;
	assign kind = kind_q;
	assign row_index = row_index_q;
	assign row_bits = row_bits_q;
	assign last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_row_q <= clamp_row(RST_START_ROW);
			pos_col_q <= clamp_col(RST_START_COL);
			heading_q <= RST_START_HEADING;
			pen_q <= 1'b0;
			cur_q <= '0;
			end_q <= '0;
			mask_q <= '0;
			paint_s1 <= '0;
			res_valid_q <= 1'b0;
			kind_q <= KIND_ROW;
			row_index_q <= '0;
			row_bits_q <= '0;
			last_q <= 1'b0;
		end else begin
			paint_s1.valid <= 1'b0;
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.cmd.kind)
							CMD_PEN_UP:   pen_q <= 1'b0;
							CMD_PEN_DOWN: pen_q <= 1'b1;
							CMD_RIGHT:    heading_q <= heading_q + HEAD_W'(1);
							CMD_LEFT:     heading_q <= heading_q - HEAD_W'(1);
							CMD_MOVE: begin
								if (vert) begin
									cur_q <= ROW_W'(lo_w);
									end_q <= ROW_W'(hi_w);
									mask_q <= GRID_COLS'(1) << pos_col_q;
								end else begin
									cur_q <= pos_row_q;
									end_q <= pos_row_q;
									mask_q <= hmask;
								end
								pos_row_q <= ROW_W'(new_row_w);
								pos_col_q <= COL_W'(new_col_w);
								state_q <= ST_PAINT;
							end
							CMD_END: begin
								cur_q <= '0;
								end_q <= ROW_W'(OUT_ROWS - 1);
								state_q <= ST_READ;
							end
							CMD_BAD: state_q <= ST_ERR;
							default: ;
						endcase
					end
				end
				ST_PAINT: begin
					paint_s1.valid <= 1'b1;
					paint_s1.row <= cur_q;
					paint_s1.mask <= mask_q;
					paint_s1.pen <= pen_q;
					if (cur_q == end_q) begin
						state_q <= ST_IDLE;
					end else begin
						cur_q <= cur_q + ROW_W'(1);
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						kind_q <= KIND_ROW;
						row_index_q <= ROW_IDX_W'(cur_q);
						row_bits_q <= ROW_BITS_W'(rd_data);
						last_q <= (cur_q == end_q);
						if (cur_q == end_q) begin
							pos_row_q <= clamp_row(start_cfg.row);
							pos_col_q <= clamp_col(start_cfg.col);
							heading_q <= start_cfg.heading;
							state_q <= ST_IDLE;
						end else begin
							cur_q <= cur_q + ROW_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						kind_q <= KIND_ERR;
						row_index_q <= '0;
						row_bits_q <= '0;
						last_q <= 1'b1;
						pos_row_q <= clamp_row(start_cfg.row);
						pos_col_q <= clamp_col(start_cfg.col);
						heading_q <= start_cfg.heading;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/turtle_raster_plotter.sv]
// top level of the turtle raster plotter: config registers, front, back and grid memory
//
// channel   dir  handshake              payload
// cmd       in   cmd_valid / cmd_stall  opcode, steps
// res       out  res_valid / res_stall  kind, row_index, row_bits, last
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// the front takes one command a cycle while its two-entry queue has room; display and
//   zero-length moves are dropped there and never reach the back
// back: pen and turn set turtle state; a move reads and rewrites each painted row
//   (one row east or west, up to one per grid row north or south)
// end reads each output row through the single grid read port and sends it out
// reset clears the grid through per-row valid bits at once, no clearing pass
// a stalled result holds in the output register; the queue keeps taking commands

`default_nettype none

module turtle_raster_plotter
	import trp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_stall,
	input  wire logic [OPCODE_W-1:0]   opcode,
	input  wire logic [STEPS_W-1:0]    steps,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic                       kind,
	output logic [ROW_IDX_W-1:0]       row_index,
	output logic [ROW_BITS_W-1:0]      row_bits,
	output logic                       last,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	start_cfg_t start_cfg_q;
	q_head_t q_head;
	logic pop;
	mem_rd_req_t rd_req;
	mem_wr_req_t wr_req;
	logic [GRID_COLS-1:0] rd_data;

	// start registers; they take effect at the next end or bad command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_cfg_q.row <= RST_START_ROW;
			start_cfg_q.col <= RST_START_COL;
			start_cfg_q.heading <= RST_START_HEADING;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_ROW:     start_cfg_q.row <= cfg_data[START_W-1:0];
				REG_START_COL:     start_cfg_q.col <= cfg_data[START_W-1:0];
				REG_START_HEADING: start_cfg_q.heading <= cfg_data[HEAD_W-1:0];
				default: ;
			endcase
		end
	end

	// decode and queue
	trp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.opcode    (opcode),
		.steps     (steps),
		.pop       (pop),
		.head      (q_head)
	);

	// grid rows
	trp_grid_mem u_grid (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_req  (rd_req),
		.rd_data (rd_data),
		.wr_req  (wr_req)
	);

	// execution and result register
	trp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_cfg (start_cfg_q),
		.head      (q_head),
		.pop       (pop),
		.rd_req    (rd_req),
		.rd_data   (rd_data),
		.wr_req    (wr_req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.kind      (kind),
		.row_index (row_index),
		.row_bits  (row_bits),
		.last      (last)
	);

	// the back only pulls a queued command
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_head.valid)
		else $error("command popped from an empty queue");

	// a paint write never collides with a read of the same row
	a_no_row_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_req.en && wr_req.en) |-> (rd_req.addr != wr_req.addr))
		else $error("grid read and write hit the same row");

	// a pending paint write blocks the next command
	a_drain_before_pop: assert property (@(posedge clk) disable iff (!arst_n)
		wr_req.en |-> !pop)
		else $error("command taken while a paint write is pending");

	// error results are a single blank final item
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (kind == KIND_ERR)) |-> (last && (row_index == '0) && (row_bits == '0)))
		else $error("malformed error result");

endmodule

`default_nettype wire

[verif/tb_turtle_raster_plotter.sv]
// testbench of the turtle raster plotter: command stimulus, grid predictor and result checks
`timescale 1ns / 1ps

// one result item as the plotter should send it
typedef struct {
	logic                               kind;
	logic [trp_pkg::ROW_IDX_W-1:0]      row_index;
	logic [trp_pkg::ROW_BITS_W-1:0]     row_bits;
	logic                               last;
} raster_row_t;

// keeps its own grid, turtle and start registers and the rows still owed by the plotter
class plotter_scoreboard;
	logic [trp_pkg::GRID_COLS-1:0] grid [trp_pkg::GRID_ROWS];
	int                            pos_row;
	int                            pos_col;
	logic [trp_pkg::HEAD_W-1:0]    heading;
	bit                            pen_down;
	logic [trp_pkg::START_W-1:0]   start_row;
	logic [trp_pkg::START_W-1:0]   start_col;
	logic [trp_pkg::HEAD_W-1:0]    start_heading;
	raster_row_t                   pending_rows [$];
	int                            errors;
	int                            n_cmds;
	int                            n_dumps;
	int                            n_bad;
	int                            n_rows_seen;

	function new();
		foreach (grid[r])
			grid[r] = '0;
		start_row = trp_pkg::RST_START_ROW;
		start_col = trp_pkg::RST_START_COL;
		start_heading = trp_pkg::RST_START_HEADING;
		pen_down = 1'b0;
		errors = 0;
		n_cmds = 0;
		n_dumps = 0;
		n_bad = 0;
		n_rows_seen = 0;
		go_home();
	endfunction

	// start values clamped to the grid
	function void go_home();
		pos_row = (int'(start_row) >= trp_pkg::GRID_ROWS) ? trp_pkg::GRID_ROWS - 1
			: int'(start_row);
		pos_col = (int'(start_col) >= trp_pkg::GRID_COLS) ? trp_pkg::GRID_COLS - 1
			: int'(start_col);
		heading = start_heading;
	endfunction

	// a new start only shows at the next end or bad command
	function void write_reg(logic [trp_pkg::CFG_IDX_W-1:0] idx,
			logic [trp_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			trp_pkg::REG_START_ROW: start_row = val[trp_pkg::START_W-1:0];
			trp_pkg::REG_START_COL: start_col = val[trp_pkg::START_W-1:0];
			trp_pkg::REG_START_HEADING: start_heading = val[trp_pkg::HEAD_W-1:0];
			default: ;
		endcase
	endfunction

	// paint n cells from the current one along the heading, clipped, then advance
	function void draw_line(int n);
		int dr;
		int dc;
		int r;
		int c;
		dr = 0;
		dc = 0;
		case (heading)
			trp_pkg::HEAD_NORTH: dr = -1;
			trp_pkg::HEAD_EAST: dc = 1;
			trp_pkg::HEAD_SOUTH: dr = 1;
			default: dc = -1;
		endcase
		for (int i = 0; i < n; i++) begin
			r = pos_row + dr * i;
			c = pos_col + dc * i;
			if (r < 0 || r >= trp_pkg::GRID_ROWS || c < 0 || c >= trp_pkg::GRID_COLS)
				break;
			grid[r][c] = pen_down;
		end
		r = pos_row + dr * n;
		c = pos_col + dc * n;
		pos_row = (r < 0) ? 0 : (r >= trp_pkg::GRID_ROWS) ? trp_pkg::GRID_ROWS - 1 : r;
		pos_col = (c < 0) ? 0 : (c >= trp_pkg::GRID_COLS) ? trp_pkg::GRID_COLS - 1 : c;
	endfunction

	function void note_command(logic [trp_pkg::OPCODE_W-1:0] op,
			logic [trp_pkg::STEPS_W-1:0] n);
		raster_row_t row;
		n_cmds++;
		case (op)
			trp_pkg::OP_PEN_UP: pen_down = 1'b0;
			trp_pkg::OP_PEN_DOWN: pen_down = 1'b1;
			trp_pkg::OP_RIGHT: heading = heading + 2'd1;
			trp_pkg::OP_LEFT: heading = heading - 2'd1;
			trp_pkg::OP_MOVE: draw_line(int'(n));
			trp_pkg::OP_DISPLAY: ;
			trp_pkg::OP_END: begin
				n_dumps++;
				for (int r = 0; r < trp_pkg::OUT_ROWS; r++) begin
					row.kind = trp_pkg::KIND_ROW;
					row.row_index = r[trp_pkg::ROW_IDX_W-1:0];
					row.row_bits = trp_pkg::ROW_BITS_W'(grid[r]);
					row.last = (r == trp_pkg::OUT_ROWS - 1);
					pending_rows.push_back(row);
				end
				go_home();
			end
			default: begin
				n_bad++;
				row.kind = trp_pkg::KIND_ERR;
				row.row_index = '0;
				row.row_bits = '0;
				row.last = 1'b1;
				pending_rows.push_back(row);
				go_home();
			end
		endcase
	endfunction

	function void check_result(logic k, logic [trp_pkg::ROW_IDX_W-1:0] idx,
			logic [trp_pkg::ROW_BITS_W-1:0] bits, logic lst);
		raster_row_t want;
		n_rows_seen++;
		if (pending_rows.size() == 0) begin
			$error("result with nothing expected: kind %0d row_index %0d row_bits %h last %0d",
				k, idx, bits, lst);
			errors++;
			return;
		end
		want = pending_rows.pop_front();
		if (k !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, k);
			errors++;
		end
		if (idx !== want.row_index) begin
			$error("row_index: expected %0d, got %0d", want.row_index, idx);
			errors++;
		end
		if (bits !== want.row_bits) begin
			$error("row_bits: expected %h, got %h", want.row_bits, bits);
			errors++;
		end
		if (lst !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, lst);
			errors++;
		end
	endfunction
endclass

module tb_turtle_raster_plotter;
	import trp_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	logic [OPCODE_W-1:0]   opcode = '0;
	logic [STEPS_W-1:0]    steps = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic                  kind;
	logic [ROW_IDX_W-1:0]  row_index;
	logic [ROW_BITS_W-1:0] row_bits;
	logic                  last;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	plotter_scoreboard plot_sb = new();

	// when set, neither side inserts gaps
	bit calm = 1'b0;
	int n_settings = 0;

	turtle_raster_plotter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.opcode    (opcode),
		.steps     (steps),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.kind      (kind),
		.row_index (row_index),
		.row_bits  (row_bits),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit is_known_op(logic [OPCODE_W-1:0] op);
		case (op)
			OP_PEN_UP, OP_PEN_DOWN, OP_RIGHT, OP_LEFT, OP_MOVE, OP_DISPLAY, OP_END:
				return 1'b1;
			default:
				return 1'b0;
		endcase
	endfunction

	// any opcode outside the command set
	function automatic logic [OPCODE_W-1:0] pick_bad_op();
		logic [OPCODE_W-1:0] op;
		do
			op = OPCODE_W'($urandom_range(0, 15));
		while (is_known_op(op));
		return op;
	endfunction

	// move lengths: mostly short, some across the whole grid, some full scale
	function automatic logic [STEPS_W-1:0] pick_steps();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return STEPS_W'($urandom_range(0, 12));
		if (roll < 93)
			return STEPS_W'($urandom_range(0, 63));
		return '1;
	endfunction

	// result side: check every accepted row, stall at random
	always @(posedge clk) begin
		int stall_left;
		if (arst_n) begin
			if (res_valid && !res_stall)
				plot_sb.check_result(kind, row_index, row_bits, last);
			if (stall_left > 0 && !calm) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
				stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	// present one command item, wait for it to be taken, keep valid high afterwards
	task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [STEPS_W-1:0] n);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= op;
		steps <= n;
		do
			@(posedge clk);
		while (cmd_stall);
		plot_sb.note_command(op, n);
	endtask

	// stop sending until every owed row is back, then let a long move finish
	task automatic drain();
		cmd_valid <= 1'b0;
		while (plot_sb.pending_rows.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// write all three start registers back to back; the plotter is idle here
	task automatic set_start(input logic [START_W-1:0] row, input logic [START_W-1:0] col,
			input logic [CFG_DATA_W-1:0] head_data);
		cfg_we <= 1'b1;
		cfg_index <= REG_START_ROW;
		cfg_data <= row;
		@(posedge clk);
		plot_sb.write_reg(REG_START_ROW, row);
		cfg_index <= REG_START_COL;
		cfg_data <= col;
		@(posedge clk);
		plot_sb.write_reg(REG_START_COL, col);
		cfg_index <= REG_START_HEADING;
		cfg_data <= head_data;
		@(posedge clk);
		plot_sb.write_reg(REG_START_HEADING, head_data);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// one pen, turn, move or display command with random content
	task automatic send_quiet_cmd();
		int roll;
		logic [STEPS_W-1:0] junk;
		roll = $urandom_range(0, 19);
		junk = STEPS_W'($urandom_range(0, 63));
		if (roll < 2)
			send_cmd(OP_PEN_UP, junk);
		else if (roll < 5)
			send_cmd(OP_PEN_DOWN, junk);
		else if (roll < 8)
			send_cmd(OP_RIGHT, junk);
		else if (roll < 11)
			send_cmd(OP_LEFT, junk);
		else if (roll < 12)
			send_cmd(OP_DISPLAY, junk);
		else
			send_cmd(OP_MOVE, pick_steps());
	endtask

	// mostly drawing programs closed by end; some left open, some cut by a bad command
	task automatic run_programs(input int count);
		int sent;
		int len;
		int roll;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(2, 14);
			repeat (len) begin
				if ($urandom_range(0, 29) == 0)
					send_cmd(pick_bad_op(), STEPS_W'($urandom_range(0, 63)));
				else
					send_quiet_cmd();
				sent++;
			end
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				send_cmd(pick_bad_op(), STEPS_W'($urandom_range(0, 63)));
				sent++;
			end else if (roll > 1) begin
				send_cmd(OP_END, STEPS_W'($urandom_range(0, 63)));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// far corner heading west, held back until the first end
		set_start(5'd31, 5'd31, {3'b111, HEAD_WEST});

		// directed: from the reset start, row 0 column 0 heading south
		send_cmd(OP_DISPLAY, '1);
		send_cmd(OP_PEN_DOWN, '0);
		send_cmd(OP_MOVE, '1);          // full column, clipped at the bottom edge
		send_cmd(OP_LEFT, '0);          // now east
		send_cmd(OP_MOVE, 6'd5);
		send_cmd(OP_MOVE, '0);          // zero steps paints nothing
		send_cmd(OP_LEFT, '1);          // now north
		send_cmd(OP_MOVE, '1);          // clipped at the top edge
		send_cmd(OP_RIGHT, '0);         // east again
		send_cmd(OP_MOVE, '1);          // clipped at the right edge
		send_cmd(OP_RIGHT, '1);
		send_cmd(OP_RIGHT, '0);         // west
		send_cmd(OP_MOVE, 6'd40);       // clipped at the left edge
		send_cmd(OP_PEN_UP, '1);
		send_cmd(OP_LEFT, '0);          // south, erase part of column 0
		send_cmd(OP_MOVE, 6'd10);
		send_cmd(OP_END, '0);           // dump, then the new start applies
		send_cmd(4'd0, '0);
		send_cmd(4'd7, '1);
		send_cmd(4'd8, '0);
		send_cmd(4'd15, '1);
		send_cmd(OP_PEN_DOWN, '0);
		send_cmd(OP_MOVE, '1);          // west from the far corner
		send_cmd(OP_RIGHT, '0);         // now north
		send_cmd(OP_MOVE, 6'd3);
		send_cmd(OP_END, '1);
		drain();

		// random phases, each under a different start setting
		set_start(5'd0, 5'd0, {3'b000, HEAD_NORTH});
		run_programs(50);
		drain();

		calm = 1'b1;
		set_start(5'd31, 5'd0, {3'b010, HEAD_EAST});
		run_programs(50);
		drain();
		calm = 1'b0;

		set_start(START_W'($urandom_range(0, 31)), START_W'($urandom_range(0, 31)),
			CFG_DATA_W'($urandom_range(0, 31)));
		run_programs(50);
		drain();

		set_start(5'd16, 5'd31, {3'b101, HEAD_SOUTH});
		run_programs(50);
		send_cmd(OP_END, '0);
		drain();

		if (plot_sb.pending_rows.size() != 0) begin
			$error("%0d expected rows never arrived", plot_sb.pending_rows.size());
			plot_sb.errors++;
		end
		$display("covered %0d commands under %0d start settings: %0d grid dumps, %0d bad commands",
			plot_sb.n_cmds, n_settings, plot_sb.n_dumps, plot_sb.n_bad);
		$display("checked %0d result items, %0d mismatches", plot_sb.n_rows_seen,
			plot_sb.errors);
		if (plot_sb.errors == 0)
			$display("tb_turtle_raster_plotter: clean");
		else
			$display("tb_turtle_raster_plotter: errors");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("tb_turtle_raster_plotter: errors");
		$finish;
	end

endmodule
